// ===== design/ps2mt_pkg.sv =====
// ----------------------------------------------------------------------------
// ps2mt_pkg
// Types and constants shared by the PS/2 mouse packet tracker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ps2mt_pkg;

  localparam int RX_W    = 8;
  localparam int EXT_W   = 12;
  localparam int POS_W   = 13;
  localparam int CIDX_W  = 8;
  localparam int CALC_W  = 15;

  localparam int SYNC_BIT  = 3;
  localparam int XSIGN_BIT = 4;
  localparam int YSIGN_BIT = 5;

  localparam logic [CIDX_W-1:0] REG_HALF_WIDTH  = 8'd0;
  localparam logic [CIDX_W-1:0] REG_HALF_HEIGHT = 8'd1;

  localparam logic [EXT_W-1:0] HALF_WIDTH_RST  = 12'd512;
  localparam logic [EXT_W-1:0] HALF_HEIGHT_RST = 12'd384;

  typedef struct packed {
    logic            x_neg;
    logic            y_neg;
    logic [RX_W-1:0] dx;
    logic [RX_W-1:0] dy;
  } pkt_t;

  typedef struct packed {
    logic [EXT_W-1:0] half_width;
    logic [EXT_W-1:0] half_height;
  } extent_t;

endpackage

`default_nettype wire

// ===== design/ps2mt_if.sv =====
// ----------------------------------------------------------------------------
// ps2mt_if
// Valid/ready channels of the tracker: received bytes, positions, config.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface ps2mt_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface ps2mt_pos_if;
  logic              valid;
  logic              ready;
  logic signed [12:0] pos_x;
  logic signed [12:0] pos_y;
  modport source (output valid, output pos_x, output pos_y, input ready);
  modport sink   (input valid, input pos_x, input pos_y, output ready);
endinterface

interface ps2mt_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [11:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== design/ps2_mouse_packet_tracker.sv =====
// ----------------------------------------------------------------------------
// ps2_mouse_packet_tracker
// Frames PS/2 mouse bytes into packets and tracks a clamped cursor position.
//
//   channel  role    payload
//   rx       sink    rx_byte[7:0]
//   pos      source  pos_x[12:0] signed, pos_y[12:0] signed
//   cfg      sink    index[7:0], data[11:0]  (0 half_width, 1 half_height)
//
// One byte is taken every cycle while rx is ready; a completed packet shows its
// position via the packet and result registers once its third byte is taken.
// Reset clears framing, cursor to zero and extents to 512 by 384.
// A stalled result holds; rx keeps flowing until the packet register is full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2_mouse_packet_tracker import ps2mt_pkg::*; #(
  parameter int CURSOR_W = 8,
  parameter int CURSOR_H = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  ps2mt_rx_if.sink    rx,
  ps2mt_pos_if.source pos,
  ps2mt_cfg_if.sink   cfg
);

  extent_t extent;
  pkt_t    pkt;
  logic    pkt_valid;
  logic    pkt_ready;

  ps2mt_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .extent (extent)
  );

  ps2mt_framer u_framer (
    .clk       (clk),
    .rst       (rst),
    .rx        (rx),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt)
  );

  ps2mt_clamp #(
    .CURSOR_W (CURSOR_W),
    .CURSOR_H (CURSOR_H)
  ) u_clamp (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .pkt       (pkt),
    .extent    (extent),
    .pos       (pos)
  );

endmodule

`default_nettype wire

// ===== design/ps2mt_cfg.sv =====
// ----------------------------------------------------------------------------
// ps2mt_cfg
// Screen half-extent registers written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_cfg import ps2mt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ps2mt_cfg_if.sink  cfg,
  output extent_t    extent
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      extent.half_width  <= HALF_WIDTH_RST;
      extent.half_height <= HALF_HEIGHT_RST;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_HALF_WIDTH:  extent.half_width  <= cfg.data;
        REG_HALF_HEIGHT: extent.half_height <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2mt_framer.sv =====
// ----------------------------------------------------------------------------
// ps2mt_framer
// Frames received bytes into three-byte packets and registers each packet.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_framer import ps2mt_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  ps2mt_rx_if.sink   rx,
  output logic       pkt_valid,
  input  wire logic  pkt_ready,
  output pkt_t       pkt
);

  localparam logic [1:0] PH_FIRST = 2'd0;
  localparam logic [1:0] PH_X     = 2'd1;
  localparam logic [1:0] PH_Y     = 2'd2;

  logic [1:0]      phase;
  logic [RX_W-1:0] flags_byte;
  logic [RX_W-1:0] dx_byte;
  logic            accept;

  assign rx.ready = !pkt_valid || pkt_ready;
  assign accept   = rx.valid && rx.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_FIRST;
      pkt_valid <= 1'b0;
    end else begin
      if (pkt_ready) pkt_valid <= 1'b0;
      if (accept) begin
        case (phase)
          PH_X: begin
            phase <= PH_Y;
          end
          PH_Y: begin
            phase     <= PH_FIRST;
            pkt_valid <= 1'b1;
          end
          default: begin
            phase <= rx.rx_byte[SYNC_BIT] ? PH_X : PH_FIRST;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (phase)
        PH_X: dx_byte <= rx.rx_byte;
        PH_Y: begin
          pkt.x_neg <= flags_byte[XSIGN_BIT];
          pkt.y_neg <= flags_byte[YSIGN_BIT];
          pkt.dx    <= dx_byte;
          pkt.dy    <= rx.rx_byte;
        end
        default: flags_byte <= rx.rx_byte;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== design/ps2mt_clamp.sv =====
// ----------------------------------------------------------------------------
// ps2mt_clamp
// Adds packet movement to the cursor, clamps to the screen and holds result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ps2mt_clamp import ps2mt_pkg::*; #(
  parameter int CURSOR_W = 8,
  parameter int CURSOR_H = 8
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   pkt_valid,
  output logic        pkt_ready,
  input  wire pkt_t   pkt,
  input  wire extent_t extent,
  ps2mt_pos_if.source pos
);

  localparam logic signed [CALC_W-1:0] CUR_W = CALC_W'(CURSOR_W);
  localparam logic signed [CALC_W-1:0] CUR_H = CALC_W'(CURSOR_H);

  logic signed [POS_W-1:0]  cur_x;
  logic signed [POS_W-1:0]  cur_y;
  logic                     out_valid;
  logic                     take;
  logic signed [CALC_W-1:0] hw;
  logic signed [CALC_W-1:0] hh;
  logic signed [CALC_W-1:0] nx;
  logic signed [CALC_W-1:0] ny;
  logic signed [CALC_W-1:0] nx_lo;
  logic signed [CALC_W-1:0] ny_hi;
  logic signed [CALC_W-1:0] x_next;
  logic signed [CALC_W-1:0] y_next;

  assign pkt_ready = !out_valid || pos.ready;
  assign take      = pkt_valid && pkt_ready;

  always_comb begin
    hw = CALC_W'({1'b0, extent.half_width});
    hh = CALC_W'({1'b0, extent.half_height});
    nx = CALC_W'(cur_x) + {{(CALC_W-RX_W){pkt.x_neg}}, pkt.dx};
    ny = CALC_W'(cur_y) + {{(CALC_W-RX_W){pkt.y_neg}}, pkt.dy};
    nx_lo  = (nx < -hw) ? -hw : nx;
    x_next = (nx_lo > hw - CUR_W) ? hw - CUR_W : nx_lo;
    ny_hi  = (ny > hh) ? hh : ny;
    y_next = (ny_hi < CUR_H - hh) ? CUR_H - hh : ny_hi;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pos.ready) out_valid <= 1'b0;
      if (take) begin
        cur_x     <= x_next[POS_W-1:0];
        cur_y     <= y_next[POS_W-1:0];
        out_valid <= 1'b1;
      end
    end
  end

  assign pos.valid = out_valid;
  assign pos.pos_x = cur_x;
  assign pos.pos_y = cur_y;

endmodule

`default_nettype wire
